// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QHS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define QHS_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define QHS_ASSERT(label, clk, rst, prop)
`define QHS_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/qhs_pkg.sv =====
// Package for the quicksort sorter: sizes, types and value conversions.
`default_nettype none
package qhs_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int SAMPLE_W    = 32;
   localparam int IDX_W       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
   localparam int STACK_DEPTH = MAX_ITEMS;
   localparam int STK_IW      = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [IDX_W-1:0]              idx_type;
   typedef logic [CNT_W-1:0]              cnt_type;

   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      value_type wr_data;
      idx_type   rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic    start;
      cnt_type count;
   } sort_cmd_type;

   typedef struct packed {
      idx_type lo;
      idx_type hi;
   } range_type;

   // sign-extend the sample to 64 bits, then keep the stored width
   function automatic value_type to_value(input logic signed [SAMPLE_W-1:0] x);
      logic signed [63:0] w;
      w = 64'(x);
      return w[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [SAMPLE_W-1:0] from_value(input value_type v);
      logic signed [63:0] w;
      w = 64'(v);
      return w[SAMPLE_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/qhs_store.sv =====
// Element store: one write port, one registered read port.
`default_nettype none
module qhs_store (
   input  wire logic                 clock,
   input  wire qhs_pkg::mem_req_type mem_req,
   output qhs_pkg::value_type        rd_data
);

   qhs_pkg::value_type mem [qhs_pkg::MAX_ITEMS];
   qhs_pkg::value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/qhs_seq.sv =====
// Sort sequencer: Hoare partition over the store with an explicit range stack.
`default_nettype none
module qhs_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire qhs_pkg::sort_cmd_type cmd,
   input  wire qhs_pkg::value_type    rd_data,
   output qhs_pkg::mem_req_type       mem_req,
   output logic                       done
);

   typedef enum logic [3:0] {
      S_IDLE, S_POP, S_RANGE, S_PIVOT, S_SCAN_J, S_SCAN_I, S_SWAP, S_PUSH_BIG, S_PUSH_SMALL
   } state_type;

   state_type              state_ff, state_in;
   logic [qhs_pkg::SP_W-1:0] sp_ff, sp_in, sp_dec;
   qhs_pkg::cnt_type       n_ff, n_in;
   qhs_pkg::idx_type       p_ff, p_in, r_ff, r_in, i_ff, i_in, j_ff, j_in;
   qhs_pkg::value_type     pivot_ff, pivot_in, aj_ff, aj_in, hold_ff, hold_in;
   logic                   done_ff, done_in;

   qhs_pkg::range_type     stack [qhs_pkg::STACK_DEPTH];
   qhs_pkg::range_type     stk_rd_ff;
   qhs_pkg::range_type     stk_wdata;
   logic                   stk_we;
   logic [qhs_pkg::STK_IW-1:0] stk_raddr;

   logic                   push_req;
   qhs_pkg::idx_type       push_lo, push_hi;
   logic                   left_big;
   qhs_pkg::cnt_type       last_idx;

   assign sp_dec   = sp_ff - 1'b1;
   assign left_big = (j_ff - p_ff) > (r_ff - j_ff - 1'b1);
   assign last_idx = cmd.count - 1'b1;

   always_comb begin
      state_in = state_ff;
      sp_in    = sp_ff;
      n_in     = n_ff;
      p_in     = p_ff;
      r_in     = r_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      pivot_in = pivot_ff;
      aj_in    = aj_ff;
      hold_in  = hold_ff;
      done_in  = 1'b0;
      push_req = 1'b0;
      push_lo  = '0;
      push_hi  = '0;
      stk_raddr = sp_dec[qhs_pkg::STK_IW-1:0];
      mem_req  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               n_in     = cmd.count;
               push_req = 1'b1;
               push_lo  = '0;
               push_hi  = last_idx[qhs_pkg::IDX_W-1:0];
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               sp_in    = sp_dec;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            p_in = stk_rd_ff.lo;
            r_in = stk_rd_ff.hi;
            i_in = stk_rd_ff.lo;
            j_in = stk_rd_ff.hi;
            mem_req.rd_addr = stk_rd_ff.lo;
            if (stk_rd_ff.lo >= stk_rd_ff.hi ||
                qhs_pkg::CNT_W'(stk_rd_ff.hi) >= n_ff) begin
               state_in = S_POP;
            end else begin
               state_in = S_PIVOT;
            end
         end
         S_PIVOT: begin
            pivot_in        = rd_data;
            mem_req.rd_addr = j_ff;
            state_in        = S_SCAN_J;
         end
         S_SCAN_J: begin
            // rd_data holds A[j]; walk j down while the pivot is below it
            if (pivot_ff < rd_data) begin
               j_in            = j_ff - 1'b1;
               mem_req.rd_addr = j_ff - 1'b1;
            end else begin
               aj_in           = rd_data;
               mem_req.rd_addr = i_ff;
               state_in        = S_SCAN_I;
            end
         end
         S_SCAN_I: begin
            if (pivot_ff > rd_data) begin
               i_in            = i_ff + 1'b1;
               mem_req.rd_addr = i_ff + 1'b1;
            end else if (i_ff < j_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = i_ff;
               mem_req.wr_data = aj_ff;
               hold_in         = rd_data;
               state_in        = S_SWAP;
            end else begin
               state_in = S_PUSH_BIG;
            end
         end
         S_SWAP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = j_ff;
            mem_req.wr_data = hold_ff;
            mem_req.rd_addr = j_ff - 1'b1;
            i_in            = i_ff + 1'b1;
            j_in            = j_ff - 1'b1;
            state_in        = S_SCAN_J;
         end
         S_PUSH_BIG: begin
            // larger side goes down first so the smaller is popped next
            push_req = 1'b1;
            if (left_big) begin
               push_lo = p_ff;
               push_hi = j_ff;
            end else begin
               push_lo = j_ff + 1'b1;
               push_hi = r_ff;
            end
            state_in = S_PUSH_SMALL;
         end
         S_PUSH_SMALL: begin
            push_req = 1'b1;
            if (left_big) begin
               push_lo = j_ff + 1'b1;
               push_hi = r_ff;
            end else begin
               push_lo = p_ff;
               push_hi = j_ff;
            end
            state_in = S_POP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      stk_we    = 1'b0;
      stk_wdata = '{lo: push_lo, hi: push_hi};
      if (push_req && push_lo < push_hi &&
          sp_ff < qhs_pkg::SP_W'(qhs_pkg::STACK_DEPTH)) begin
         stk_we = 1'b1;
         sp_in  = sp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack[sp_ff[qhs_pkg::STK_IW-1:0]] <= stk_wdata;
      end
      stk_rd_ff <= stack[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         done_ff  <= done_in;
      end
      n_ff     <= n_in;
      p_ff     <= p_in;
      r_ff     <= r_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      pivot_ff <= pivot_in;
      aj_ff    <= aj_in;
      hold_ff  <= hold_in;
   end

   assign done = done_ff;

endmodule
`default_nettype wire

// ===== rtl/quicksort_hoare_sorter.sv =====
// Top level: loads the set, runs the sort sequencer, then streams the sorted values.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_stall   | req_sample_value, req_end_of_set
//   rsp     | out       | rsp_valid / rsp_stall   | rsp_sorted_value, rsp_final_result,
//           |           |                         | rsp_overflow_flag
//
// Values load at one request a cycle until end_of_set. The sort then runs in the
// sequencer over the store, with one write port and one registered read port; an
// already sorted set of N values is the slow case. Requests are stalled from then
// until the last result is taken. Results leave one at a time, each read from the
// store in ST_EMIT_LOAD and then held in ST_EMIT_HOLD while rsp_stall is high.
// Reset clears control state only; the store and range stack are not cleared.
`default_nettype none
`include "assert_macros.svh"
module quicksort_hoare_sorter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [qhs_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  wire logic                                  req_end_of_set,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [qhs_pkg::SAMPLE_W-1:0]        rsp_sorted_value,
   output logic                                       rsp_final_result,
   output logic                                       rsp_overflow_flag
);

   typedef enum logic [1:0] {
      ST_LOAD, ST_SORT, ST_EMIT_LOAD, ST_EMIT_HOLD
   } state_type;

   state_type             state_ff, state_in;
   qhs_pkg::cnt_type      count_ff, count_in;
   logic                  drop_ff, drop_in;
   qhs_pkg::idx_type      k_ff, k_in;
   logic                  start_ff, start_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [qhs_pkg::SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_final_ff, rsp_final_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   qhs_pkg::mem_req_type  top_req, seq_req, mem_req;
   qhs_pkg::value_type    rd_data;
   qhs_pkg::sort_cmd_type cmd;
   logic                  sort_done;
   logic                  loading;
   logic                  sorting;
   logic                  rsp_last_taken;

   assign cmd = '{start: start_ff, count: count_ff};

   assign loading        = (state_ff == ST_LOAD);
   assign sorting        = (state_ff == ST_SORT);
   assign rsp_last_taken = rsp_valid_ff && !rsp_stall && rsp_final_ff;

   qhs_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data),
      .mem_req (seq_req),
      .done    (sort_done)
   );

   assign mem_req = sorting ? seq_req : top_req;

   qhs_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_stall = !loading;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      k_in         = k_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      top_req      = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < qhs_pkg::CNT_W'(qhs_pkg::MAX_ITEMS)) begin
                  top_req.wr_en   = 1'b1;
                  top_req.wr_addr = count_ff[qhs_pkg::IDX_W-1:0];
                  top_req.wr_data = qhs_pkg::to_value(req_sample_value);
                  count_in        = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_end_of_set) begin
                  start_in = 1'b1;
                  state_in = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            if (sort_done) begin
               k_in            = '0;
               top_req.rd_addr = '0;
               state_in        = ST_EMIT_LOAD;
            end
         end
         ST_EMIT_LOAD: begin
            rsp_value_in = qhs_pkg::from_value(rd_data);
            rsp_final_in = (qhs_pkg::CNT_W'(k_ff) + 1'b1 == count_ff);
            rsp_ovf_in   = drop_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_final_ff) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  k_in            = k_ff + 1'b1;
                  top_req.rd_addr = k_ff + 1'b1;
                  state_in        = ST_EMIT_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      rsp_value_ff <= rsp_value_in;
      rsp_final_ff <= rsp_final_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sorted_value  = rsp_value_ff;
   assign rsp_final_result  = rsp_final_ff;
   assign rsp_overflow_flag = rsp_ovf_ff;

   `QHS_NEVER(a_no_rsp_while_loading, clock, reset, rsp_valid_ff && loading)
   `QHS_NEVER(a_count_in_range, clock, reset, count_ff > qhs_pkg::CNT_W'(qhs_pkg::MAX_ITEMS))
   `QHS_ASSERT(a_final_returns_to_load, clock, reset, rsp_last_taken |=> (loading && count_ff == '0))
   `QHS_ASSERT(a_start_only_after_load, clock, reset, start_ff |-> (sorting && $past(loading)))

endmodule
`default_nettype wire

// ===== tb/quicksort_hoare_sorter_tb.sv =====
// Testbench for the quicksort sorter: directed and random sets checked against a sorting predictor.
module quicksort_hoare_sorter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      FILL_RANDOM, FILL_NARROW, FILL_EXTREME, FILL_RISING, FILL_FALLING
   } fill_kind_type;

   typedef struct {
      logic signed [qhs_pkg::SAMPLE_W-1:0] sample;
      logic                                last;
   } sample_item_type;

   typedef struct {
      logic signed [qhs_pkg::SAMPLE_W-1:0] value;
      logic                                last;
      logic                                dropped;
   } sorted_entry_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [qhs_pkg::SAMPLE_W-1:0] req_sample_value = '0;
   logic                                req_end_of_set = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [qhs_pkg::SAMPLE_W-1:0] rsp_sorted_value;
   logic                                rsp_final_result;
   logic                                rsp_overflow_flag;

   sample_item_type    sample_queue[$];
   sorted_entry_type   sorted_due[$];
   qhs_pkg::value_type set_values[$];
   logic               set_dropped = 1'b0;
   int unsigned        send_idle_pct = 0;
   int unsigned        stall_pct = 0;
   int unsigned        fault_count = 0;
   sample_item_type    next_item;
   sorted_entry_type   head;

   quicksort_hoare_sorter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_value  (req_sample_value),
      .req_end_of_set    (req_end_of_set),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sorted_value  (rsp_sorted_value),
      .rsp_final_result  (rsp_final_result),
      .rsp_overflow_flag (rsp_overflow_flag)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stores one accepted request; on the last one of a set, queues the sorted set.
   function automatic void take_sample(input logic signed [qhs_pkg::SAMPLE_W-1:0] s,
                                       input logic eos);
      longint             wide;
      qhs_pkg::value_type v;
      qhs_pkg::value_type t;
      sorted_entry_type   e;
      int                 n;
      int                 j;
      wide = s;
      v = wide[qhs_pkg::VALUE_WIDTH-1:0];
      if (set_values.size() < qhs_pkg::MAX_ITEMS) begin
         set_values.push_back(v);
      end else begin
         set_dropped = 1'b1;
      end
      if (!eos) return;
      n = set_values.size();
      // ascending order; the partition scheme cannot change what comes out
      for (int i = 1; i < n; i++) begin
         t = set_values[i];
         j = i - 1;
         while (j >= 0 && set_values[j] > t) begin
            set_values[j + 1] = set_values[j];
            j--;
         end
         set_values[j + 1] = t;
      end
      for (int i = 0; i < n; i++) begin
         wide = set_values[i];
         e.value = wide[qhs_pkg::SAMPLE_W-1:0];
         e.last = (i == n - 1);
         e.dropped = set_dropped;
         sorted_due.push_back(e);
      end
      set_values.delete();
      set_dropped = 1'b0;
   endfunction

   function automatic logic [qhs_pkg::SAMPLE_W-1:0] pick_value(input fill_kind_type kind,
                                                               input int k, input int n);
      case (kind)
         FILL_NARROW: begin
            return qhs_pkg::SAMPLE_W'(int'($urandom_range(6)) - 3);
         end
         FILL_EXTREME: begin
            case ($urandom_range(5))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               3: return 32'hffff_ffff;
               4: return 32'h8000_0001;
               default: return 32'h7fff_fffe;
            endcase
         end
         FILL_RISING: begin
            return qhs_pkg::SAMPLE_W'(k * 37 - n * 18);
         end
         FILL_FALLING: begin
            return qhs_pkg::SAMPLE_W'(n * 18 - k * 37);
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   task automatic push_sample(input logic [qhs_pkg::SAMPLE_W-1:0] s, input logic eos);
      sample_item_type it;
      it.sample = s;
      it.last = eos;
      sample_queue.push_back(it);
   endtask

   task automatic add_set(input int n, input fill_kind_type kind);
      for (int k = 0; k < n; k++) begin
         push_sample(pick_value(kind, k, n), k == n - 1);
      end
   endtask

   task automatic add_random_sets(input int budget);
      int used;
      int n;
      used = 0;
      while (used < budget) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         add_set(n, fill_kind_type'($urandom_range(4)));
         used += n;
      end
   endtask

   // Waits for the last request to go and then for every result of it.
   task automatic drain;
      while (sample_queue.size() != 0 || req_valid) @(negedge clock);
      while (sorted_due.size() != 0) @(negedge clock);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            take_sample(req_sample_value, req_end_of_set);
         end
         if (!req_valid || !req_stall) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_sample_value <= next_item.sample;
               req_end_of_set <= next_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_due.size() == 0) begin
               $error("unexpected result: sorted_value %0d", rsp_sorted_value);
               fault_count++;
            end else begin
               head = sorted_due.pop_front();
               if (rsp_sorted_value !== head.value) begin
                  $error("sorted_value: expected %0d, got %0d", head.value, rsp_sorted_value);
                  fault_count++;
               end
               if (rsp_final_result !== head.last) begin
                  $error("final_result: expected %0b, got %0b", head.last, rsp_final_result);
                  fault_count++;
               end
               if (rsp_overflow_flag !== head.dropped) begin
                  $error("overflow_flag: expected %0b, got %0b", head.dropped,
                         rsp_overflow_flag);
                  fault_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed sets, no idling
      push_sample(32'h7fff_ffff, 1'b1);
      push_sample(32'h8000_0000, 1'b0);
      push_sample(32'h7fff_ffff, 1'b1);
      push_sample(32'h7fff_ffff, 1'b0);
      push_sample(32'h8000_0000, 1'b1);
      push_sample(32'd5, 1'b0);
      push_sample(32'd5, 1'b0);
      push_sample(32'd5, 1'b1);
      push_sample(32'h5555_5555, 1'b0);
      push_sample(32'haaaa_aaaa, 1'b0);
      push_sample(32'h0000_0000, 1'b0);
      push_sample(32'hffff_ffff, 1'b0);
      push_sample(32'h0000_0001, 1'b1);
      add_set(5, FILL_RISING);
      add_set(5, FILL_FALLING);
      drain();

      // store exactly full, then random sets
      add_set(qhs_pkg::MAX_ITEMS, fill_kind_type'($urandom_range(4)));
      add_random_sets(8);
      drain();

      // sender mostly idle; overflow set drops one plain request and the closing one
      send_idle_pct = 80;
      add_random_sets(4);
      add_set(qhs_pkg::MAX_ITEMS + 2, fill_kind_type'($urandom_range(4)));
      add_random_sets(4);
      drain();

      // receiver mostly stalling
      send_idle_pct = 0;
      stall_pct = 80;
      add_random_sets(8);
      drain();

      send_idle_pct = 14;
      stall_pct = 14;
      add_random_sets(8);
      drain();

      repeat (100) @(negedge clock);
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
